FILE: src/nrmc_pkg.sv
package nrmc_pkg;

    localparam int FIELD_CHARS_DEF = 10;

    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;

    localparam logic [3:0] FC_IDLE   = 4'd0;
    localparam logic [3:0] FC_NAME   = 4'd1;
    localparam logic [3:0] FC_TIME   = 4'd3;
    localparam logic [3:0] FC_STATUS = 4'd5;
    localparam logic [3:0] FC_DATE   = 4'd12;

    localparam logic [7:0] RMC_NAME [5] = '{8'h47, 8'h50, 8'h52, 8'h4D, 8'h43};

    localparam logic [4:0] MONTH_DAYS [12] = '{
        5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
        5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31
    };

    localparam logic [4:0] HOURS_PER_DAY = 5'd24;
    localparam logic [3:0] MONTHS        = 4'd12;
    localparam logic [4:0] MAX_DAY       = 5'd31;

    typedef enum logic {
        CMD_TIME,
        CMD_DATE
    } t_cmd_kind;

    typedef enum logic [1:0] {
        ADJ_NONE,
        ADJ_ADD,
        ADJ_SUB
    } t_adj;

    typedef struct packed {
        t_cmd_kind  kind;
        logic [6:0] v_hi;
        logic [6:0] v_mid;
        logic [6:0] v_lo;
        logic       err;
    } t_cmd;

    function automatic logic [4:0] month_len(input logic [3:0] m, input logic [6:0] y);
        logic [4:0] len;
        len = MONTH_DAYS[m - 4'd1];
        if (m == 4'd2 && y[1:0] == 2'b00) begin
            len = len + 5'd1;
        end
        return len;
    endfunction

endpackage

FILE: src/nrmc_front.sv
module nrmc_front import nrmc_pkg::*; #(
    parameter int FIELD_CHARS = FIELD_CHARS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [7:0] i_rx_char,
    input  logic       i_full,
    output logic       o_push,
    output t_cmd       o_cmd
);

    localparam int CW = $clog2(FIELD_CHARS + 1);
    localparam int IW = $clog2(FIELD_CHARS);

    logic [3:0]    r_field_count, n_field_count;
    logic [CW-1:0] r_char_count, n_char_count;
    logic [7:0]    r_chars [FIELD_CHARS];

    logic          accept;
    logic          wr_en;
    logic          name_ok;
    t_cmd_kind     kind;
    logic [5:0]    pos_ok;
    logic [3:0]    dig [6];
    logic [6:0]    val [3];

    // per-position digit decode; missing or non-digit counts as 0 with error
    always_comb begin
        logic [7:0] ch;
        for (int i = 0; i < 6; i++) begin
            ch = r_chars[i];
            pos_ok[i] = (CW'(i) < r_char_count) && (ch >= CH_ZERO) && (ch <= CH_NINE);
            dig[i] = pos_ok[i] ? 4'(ch - CH_ZERO) : 4'd0;
        end
        for (int k = 0; k < 3; k++) begin
            val[k] = 7'({3'b000, dig[2*k]} * 7'd10) + {3'b000, dig[2*k+1]};
        end
    end

    always_comb begin
        name_ok = (r_char_count == CW'(5));
        for (int i = 0; i < 5; i++) begin
            if (r_chars[i] != RMC_NAME[i]) begin
                name_ok = 1'b0;
            end
        end
    end

    always_comb begin
        accept        = i_valid && !i_full;
        n_field_count = r_field_count;
        n_char_count  = r_char_count;
        wr_en         = 1'b0;
        o_push        = 1'b0;
        kind          = CMD_TIME;
        if (accept && i_rx_char >= CH_SPACE) begin
            if (i_rx_char == CH_DOLLAR) begin
                n_field_count = FC_NAME;
                n_char_count  = '0;
            end else if (r_field_count != FC_IDLE) begin
                if (i_rx_char != CH_COMMA) begin
                    if (r_char_count < CW'(FIELD_CHARS)) begin
                        wr_en        = 1'b1;
                        n_char_count = r_char_count + CW'(1);
                    end
                end else begin
                    n_char_count = '0;
                    unique case (r_field_count)
                        FC_NAME: n_field_count = name_ok ? FC_TIME : FC_IDLE;
                        FC_TIME: begin
                            n_field_count = FC_STATUS;
                            o_push        = 1'b1;
                            kind          = CMD_TIME;
                        end
                        FC_DATE: begin
                            n_field_count = FC_IDLE;
                            o_push        = 1'b1;
                            kind          = CMD_DATE;
                        end
                        default: n_field_count = r_field_count + 4'd1;
                    endcase
                end
            end
        end
    end

    assign o_ready = !i_full;
    assign o_cmd   = '{kind: kind, v_hi: val[0], v_mid: val[1], v_lo: val[2],
                       err: ~&pos_ok};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_field_count <= FC_IDLE;
            r_char_count  <= '0;
        end else begin
            r_field_count <= n_field_count;
            r_char_count  <= n_char_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_chars[r_char_count[IW-1:0]] <= i_rx_char;
        end
    end

endmodule

FILE: src/nrmc_queue.sv
module nrmc_queue import nrmc_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    output logic o_full,
    output logic o_valid,
    output t_cmd o_head,
    input  logic i_pop
);

    t_cmd       r_entries [2];
    logic       r_wr;
    logic       r_rd;
    logic [1:0] r_count;

    assign o_full  = (r_count == 2'd2);
    assign o_valid = (r_count != 2'd0);
    assign o_head  = r_entries[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= 1'b0;
            r_rd    <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr <= ~r_wr;
            end
            if (i_pop) begin
                r_rd <= ~r_rd;
            end
            r_count <= r_count + 2'(i_push) - 2'(i_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_entries[r_wr] <= i_cmd;
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= 2'd2) else $error("queue count overflow");
    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && o_full)) else $error("push into full queue");
    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_pop && !o_valid)) else $error("pop from empty queue");

endmodule

FILE: src/nrmc_back.sv
module nrmc_back import nrmc_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic [5:0] i_cfg_wdata,
    input  logic       i_q_valid,
    input  t_cmd       i_head,
    output logic       o_pop,
    output logic       o_valid,
    input  logic       i_ready,
    output logic [4:0] o_hour,
    output logic [5:0] o_minute,
    output logic [5:0] o_second,
    output logic [4:0] o_day,
    output logic [3:0] o_month,
    output logic [6:0] o_year,
    output logic       o_digit_error
);

    logic signed [5:0] r_zone;
    t_adj              r_day_adjust;
    logic [4:0]        r_held_hour;
    logic [5:0]        r_held_minute;
    logic [5:0]        r_held_second;
    logic              r_held_err;
    logic              r_out_valid;

    logic [4:0]  r_hour, r_day;
    logic [5:0]  r_minute, r_second;
    logic [3:0]  r_month;
    logic [6:0]  r_year;
    logic        r_err;

    logic [4:0]        t_h;
    logic [5:0]        t_m, t_s;
    logic signed [5:0] tz;
    logic signed [6:0] local_h;
    logic [4:0]        n_hour;
    t_adj              n_adj;

    logic [4:0] d, ml, ml_prev;
    logic [3:0] mo;
    logic [6:0] y;
    logic [4:0] n_day;
    logic [3:0] n_month;
    logic [6:0] n_year;

    // time: saturate, shift by zone, note day carry or borrow
    always_comb begin
        t_h = (i_head.v_hi  > 7'd23) ? 5'd23 : i_head.v_hi[4:0];
        t_m = (i_head.v_mid > 7'd59) ? 6'd59 : i_head.v_mid[5:0];
        t_s = (i_head.v_lo  > 7'd59) ? 6'd59 : i_head.v_lo[5:0];
        if (r_zone < -6'sd23) begin
            tz = -6'sd23;
        end else if (r_zone > 6'sd23) begin
            tz = 6'sd23;
        end else begin
            tz = r_zone;
        end
        local_h = $signed({2'b00, t_h}) + $signed({tz[5], tz});
        if (local_h < 7'sd0) begin
            n_hour = 5'(local_h + 7'sd24);
            n_adj  = ADJ_SUB;
        end else if (local_h >= 7'sd24) begin
            n_hour = 5'(local_h - 7'sd24);
            n_adj  = ADJ_ADD;
        end else begin
            n_hour = local_h[4:0];
            n_adj  = ADJ_NONE;
        end
    end

    // date: saturate, then apply the carry or borrow with rollover
    always_comb begin
        if (i_head.v_hi == 7'd0) begin
            d = 5'd1;
        end else if (i_head.v_hi > 7'd31) begin
            d = MAX_DAY;
        end else begin
            d = i_head.v_hi[4:0];
        end
        if (i_head.v_mid == 7'd0) begin
            mo = 4'd1;
        end else if (i_head.v_mid > 7'd12) begin
            mo = MONTHS;
        end else begin
            mo = i_head.v_mid[3:0];
        end
        y       = i_head.v_lo;
        ml      = month_len(mo, y);
        ml_prev = month_len((mo == 4'd1) ? MONTHS : mo - 4'd1, y);
        n_day   = d;
        n_month = mo;
        n_year  = y;
        unique case (r_day_adjust)
            ADJ_SUB: begin
                if (d == 5'd1) begin
                    if (mo == 4'd1) begin
                        n_month = MONTHS;
                        n_day   = MAX_DAY;
                        n_year  = (y == 7'd0) ? 7'd99 : y - 7'd1;
                    end else begin
                        n_month = mo - 4'd1;
                        n_day   = ml_prev;
                    end
                end else begin
                    n_day = d - 5'd1;
                end
            end
            ADJ_ADD: begin
                if (d >= ml) begin
                    n_day = 5'd1;
                    if (mo == MONTHS) begin
                        n_month = 4'd1;
                        n_year  = (y == 7'd99) ? 7'd0 : y + 7'd1;
                    end else begin
                        n_month = mo + 4'd1;
                    end
                end else begin
                    n_day = d + 5'd1;
                end
            end
            default: ;
        endcase
    end

    assign o_pop = i_q_valid && (i_head.kind == CMD_TIME || !r_out_valid || i_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_zone        <= 6'sd0;
            r_day_adjust  <= ADJ_NONE;
            r_held_hour   <= 5'd0;
            r_held_minute <= 6'd0;
            r_held_second <= 6'd0;
            r_held_err    <= 1'b0;
            r_out_valid   <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_zone <= $signed(i_cfg_wdata);
            end
            if (o_pop && i_head.kind == CMD_TIME) begin
                r_day_adjust  <= n_adj;
                r_held_hour   <= n_hour;
                r_held_minute <= t_m;
                r_held_second <= t_s;
                r_held_err    <= i_head.err;
            end
            if (o_pop && i_head.kind == CMD_DATE) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop && i_head.kind == CMD_DATE) begin
            r_hour   <= r_held_hour;
            r_minute <= r_held_minute;
            r_second <= r_held_second;
            r_day    <= n_day;
            r_month  <= n_month;
            r_year   <= n_year;
            r_err    <= r_held_err | i_head.err;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_hour        = r_hour;
    assign o_minute      = r_minute;
    assign o_second      = r_second;
    assign o_day         = r_day;
    assign o_month       = r_month;
    assign o_year        = r_year;
    assign o_digit_error = r_err;

    a_held_hour: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_held_hour < HOURS_PER_DAY) else $error("held hour out of range");
    a_rose_on_date: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(o_pop && i_head.kind == CMD_DATE))
        else $error("result without date beat");
    a_date_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(o_pop && i_head.kind == CMD_DATE) |->
        (r_day != 5'd0 && r_month != 4'd0 && r_month <= MONTHS && r_year <= 7'd99))
        else $error("date out of range");

endmodule

FILE: src/nmea_rmc_time_date_parser.sv
// Output: o_valid rises after the date field's closing comma passes the command queue
// and r_out_valid, later only while an earlier result is still waiting for i_ready.
// Throughput: one character per cycle; the front stalls only when the
// two-entry command queue is full, which happens only while results back up.
// Reset: synchronous, active low; clears field tracking, queue, output valid,
// day adjust, held time and the zone offset (0). Field buffer is not cleared.
module nmea_rmc_time_date_parser import nrmc_pkg::*; #(
    parameter int FIELD_CHARS = FIELD_CHARS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic [5:0] i_cfg_wdata,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [7:0] i_rx_char,
    output logic       o_valid,
    input  logic       i_ready,
    output logic [4:0] o_hour,
    output logic [5:0] o_minute,
    output logic [5:0] o_second,
    output logic [4:0] o_day,
    output logic [3:0] o_month,
    output logic [6:0] o_year,
    output logic       o_digit_error
);

    logic q_full;
    logic q_push;
    t_cmd q_in;
    logic q_valid;
    t_cmd q_head;
    logic q_pop;

    nrmc_front #(
        .FIELD_CHARS(FIELD_CHARS)
    ) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .o_ready   (o_ready),
        .i_rx_char (i_rx_char),
        .i_full    (q_full),
        .o_push    (q_push),
        .o_cmd     (q_in)
    );

    nrmc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_cmd   (q_in),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_head  (q_head),
        .i_pop   (q_pop)
    );

    nrmc_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .i_q_valid     (q_valid),
        .i_head        (q_head),
        .o_pop         (q_pop),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_hour        (o_hour),
        .o_minute      (o_minute),
        .o_second      (o_second),
        .o_day         (o_day),
        .o_month       (o_month),
        .o_year        (o_year),
        .o_digit_error (o_digit_error)
    );

endmodule
